// ===== rtl/hbsd_pkg.sv =====
// Shared widths, operation codes and the table write bus of the Huffman decoder.
package hbsd_pkg;

    // Field widths of the transfer payloads
    localparam int IDX_W  = 8;
    localparam int CODE_W = 16;
    localparam int LEN_W  = 5;
    localparam int SYM_W  = 8;

    // Operation codes of an input transfer
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    // Broadcast write of one table slot
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0]  idx;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
        logic [SYM_W-1:0]  sym;
    } t_wr;

endpackage

// ===== rtl/hbsd_if.sv =====
// Valid/ready channel interfaces of the Huffman decoder.
interface hbsd_in_if;
    logic                      valid;
    logic                      ready;
    logic                      operation;
    logic [hbsd_pkg::IDX_W-1:0]  entry_index;
    logic [hbsd_pkg::CODE_W-1:0] entry_code;
    logic [hbsd_pkg::LEN_W-1:0]  entry_length;
    logic [hbsd_pkg::SYM_W-1:0]  entry_symbol;
    logic                      code_bit;

    modport source (
        output valid, operation, entry_index, entry_code, entry_length, entry_symbol,
               code_bit,
        input  ready
    );
    modport sink (
        input  valid, operation, entry_index, entry_code, entry_length, entry_symbol,
               code_bit,
        output ready
    );
endinterface

interface hbsd_out_if;
    logic                     valid;
    logic                     ready;
    logic [hbsd_pkg::SYM_W-1:0] symbol_out;
    logic                     overflow_error;

    modport source (
        output valid, symbol_out, overflow_error,
        input  ready
    );
    modport sink (
        input  valid, symbol_out, overflow_error,
        output ready
    );
endinterface

// ===== rtl/hbsd_cell.sv =====
// One table slot of the decoder chain: stores an entry and checks the passing code against it.
module hbsd_cell #(
    parameter int INDEX        = 0,
    parameter int MAX_CODE_LEN = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hbsd_pkg::t_wr                 i_wr,
    input  logic                          i_tok_valid,
    input  logic                          i_tok_found,
    input  logic [MAX_CODE_LEN-1:0]        i_tok_code,
    input  logic [$clog2(MAX_CODE_LEN+1)-1:0] i_tok_len,
    input  logic [hbsd_pkg::SYM_W-1:0]     i_tok_sym,
    output logic                          o_tok_valid,
    output logic                          o_tok_found,
    output logic [MAX_CODE_LEN-1:0]        o_tok_code,
    output logic [$clog2(MAX_CODE_LEN+1)-1:0] o_tok_len,
    output logic [hbsd_pkg::SYM_W-1:0]     o_tok_sym
);

    localparam int LW = $clog2(MAX_CODE_LEN + 1);
    localparam int CW = (LW > hbsd_pkg::LEN_W) ? LW : hbsd_pkg::LEN_W;

    // Stored entry; length clears at reset, which marks the slot unused
    logic [hbsd_pkg::CODE_W-1:0] r_code;
    logic [hbsd_pkg::LEN_W-1:0]  r_len;
    logic [hbsd_pkg::SYM_W-1:0]  r_sym;

    // Outgoing token
    logic                     r_tok_valid;
    logic                     r_tok_found;
    logic [MAX_CODE_LEN-1:0]   r_tok_code;
    logic [LW-1:0]             r_tok_len;
    logic [hbsd_pkg::SYM_W-1:0] r_tok_sym;

    logic [MAX_CODE_LEN-1:0] code_ext;
    logic [MAX_CODE_LEN-1:0] len_mask;
    logic                    wr_hit;
    logic                    entry_ok;
    logic                    len_eq;
    logic                    match;

    // Entry code widened or cut to the accumulator width, and the mask of its used bits
    for (genvar k = 0; k < MAX_CODE_LEN; k++) begin : g_bits
        if (k < hbsd_pkg::CODE_W) begin : g_have
            assign code_ext[k] = r_code[k];
        end else begin : g_zero
            assign code_ext[k] = 1'b0;
        end
        assign len_mask[k] = (CW'(k) < CW'(r_len));
    end

    assign wr_hit   = i_wr.en && (i_wr.idx == hbsd_pkg::IDX_W'(INDEX));
    assign entry_ok = (r_len != '0) && (r_sym != '0);
    assign len_eq   = (CW'(r_len) == CW'(i_tok_len));
    assign match    = i_tok_valid && !i_tok_found && entry_ok && len_eq &&
                      (((code_ext ^ i_tok_code) & len_mask) == '0);

    // Table slot write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (wr_hit) begin
            r_len <= i_wr.len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_hit) begin
            r_code <= i_wr.code;
            r_sym  <= i_wr.sym;
        end
    end

    // Token stage toward the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_valid <= 1'b0;
        end else begin
            r_tok_valid <= i_tok_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok_found <= i_tok_found || match;
        r_tok_code  <= i_tok_code;
        r_tok_len   <= i_tok_len;
        r_tok_sym   <= match ? r_sym : i_tok_sym;
    end

    assign o_tok_valid = r_tok_valid;
    assign o_tok_found = r_tok_found;
    assign o_tok_code  = r_tok_code;
    assign o_tok_len   = r_tok_len;
    assign o_tok_sym   = r_tok_sym;

endmodule

// ===== rtl/huffman_bit_serial_decoder_unit.sv =====
// Top level of the bit-serial Huffman decoder: control, accumulator, cell chain, result register.
//
// Usage:
//   i_in  carries load and decode transfers. A load writes one table slot (code, length,
//         symbol); a slot index at or beyond TABLE_DEPTH is dropped. A decode appends
//         code_bit to the pending code.
//   o_out carries results: a symbol on a code match, or overflow_error with symbol 0 when
//         MAX_CODE_LEN bits arrived with no match. A decode that completes nothing gives
//         no result.
//   Each decode sends the pending code as a token down a chain of TABLE_DEPTH cells, one
//   cell per cycle; the lowest matching slot wins. The result passes the cell registers
//   and then the output register to o_out; the block takes no new item until the token
//   has left the chain. A load leaves the input ready for the next item.
//   Reset clears every slot length (all slots unused), the pending code and the result
//   valid flag. When the receiver stalls, the result waits in the output register; the
//   block still accepts the next item, and a later result waits in a holding register
//   while the input stalls, until the output register frees.
module huffman_bit_serial_decoder_unit #(
    parameter int TABLE_DEPTH  = 256,
    parameter int MAX_CODE_LEN = 16
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    hbsd_in_if.sink    i_in,
    hbsd_out_if.source o_out
);

    localparam int LW = $clog2(MAX_CODE_LEN + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_HOLD = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [MAX_CODE_LEN-1:0]   r_pcode, n_pcode;
    logic [LW-1:0]             r_plen, n_plen;
    logic                     r_out_valid;
    logic [hbsd_pkg::SYM_W-1:0] r_out_sym;
    logic                     r_out_err;
    logic [hbsd_pkg::SYM_W-1:0] r_hold_sym;
    logic                     r_hold_err;

    hbsd_pkg::t_wr wr;
    logic          in_xfer;
    logic          dec_xfer;
    logic          out_free;
    logic          exit_valid;
    logic          exit_result;
    logic          exit_err;
    logic [MAX_CODE_LEN-1:0] acc_code;
    logic [LW-1:0]           acc_len;

    // Token wires between cells
    logic                     tok_valid [0:TABLE_DEPTH];
    logic                     tok_found [0:TABLE_DEPTH];
    logic [MAX_CODE_LEN-1:0]   tok_code  [0:TABLE_DEPTH];
    logic [LW-1:0]             tok_len   [0:TABLE_DEPTH];
    logic [hbsd_pkg::SYM_W-1:0] tok_sym   [0:TABLE_DEPTH];

    assign i_in.ready = (r_state == S_IDLE);
    assign in_xfer    = i_in.valid && i_in.ready;
    assign dec_xfer   = in_xfer && (i_in.operation == hbsd_pkg::OP_DECODE);
    assign out_free   = !r_out_valid || o_out.ready;

    // Table write bus
    always_comb begin
        wr.en   = in_xfer && (i_in.operation == hbsd_pkg::OP_LOAD);
        wr.idx  = i_in.entry_index;
        wr.code = i_in.entry_code;
        wr.len  = i_in.entry_length;
        wr.sym  = i_in.entry_symbol;
    end

    // Accumulator with the new bit appended, newest bit lowest
    assign acc_code = (r_pcode << 1) | MAX_CODE_LEN'(i_in.code_bit);
    assign acc_len  = r_plen + LW'(1);

    // Chain head
    assign tok_valid[0] = dec_xfer;
    assign tok_found[0] = 1'b0;
    assign tok_code[0]  = acc_code;
    assign tok_len[0]   = acc_len;
    assign tok_sym[0]   = '0;

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        hbsd_cell #(
            .INDEX        (i),
            .MAX_CODE_LEN (MAX_CODE_LEN)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_wr        (wr),
            .i_tok_valid (tok_valid[i]),
            .i_tok_found (tok_found[i]),
            .i_tok_code  (tok_code[i]),
            .i_tok_len   (tok_len[i]),
            .i_tok_sym   (tok_sym[i]),
            .o_tok_valid (tok_valid[i+1]),
            .o_tok_found (tok_found[i+1]),
            .o_tok_code  (tok_code[i+1]),
            .o_tok_len   (tok_len[i+1]),
            .o_tok_sym   (tok_sym[i+1])
        );
    end

    // Chain tail: a match, or an overflow when the code reached full length
    assign exit_valid  = tok_valid[TABLE_DEPTH];
    assign exit_err    = !tok_found[TABLE_DEPTH] &&
                         (tok_len[TABLE_DEPTH] >= LW'(MAX_CODE_LEN));
    assign exit_result = tok_found[TABLE_DEPTH] || exit_err;

    // Sequencer and accumulator next state
    always_comb begin
        n_state = r_state;
        n_pcode = r_pcode;
        n_plen  = r_plen;
        unique case (r_state)
            S_IDLE: begin
                if (dec_xfer) begin
                    n_pcode = acc_code;
                    n_plen  = acc_len;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (exit_valid) begin
                    if (exit_result) begin
                        n_pcode = '0;
                        n_plen  = '0;
                        n_state = out_free ? S_IDLE : S_HOLD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pcode <= '0;
            r_plen  <= '0;
        end else begin
            r_state <= n_state;
            r_pcode <= n_pcode;
            r_plen  <= n_plen;
        end
    end

    // Result parked while the output register is busy
    always_ff @(posedge i_clk) begin
        if (r_state == S_RUN && exit_valid) begin
            r_hold_sym <= exit_err ? '0 : tok_sym[TABLE_DEPTH];
            r_hold_err <= exit_err;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_RUN && exit_valid && exit_result && out_free) begin
            r_out_valid <= 1'b1;
        end else if (r_state == S_HOLD && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RUN && exit_valid && exit_result && out_free) begin
            r_out_sym <= exit_err ? '0 : tok_sym[TABLE_DEPTH];
            r_out_err <= exit_err;
        end else if (r_state == S_HOLD && out_free) begin
            r_out_sym <= r_hold_sym;
            r_out_err <= r_hold_err;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.symbol_out     = r_out_sym;
    assign o_out.overflow_error = r_out_err;

endmodule

// ===== rtl/hbsd_checker.sv =====
// Port-level checks of the Huffman decoder, bound to the top level.
module hbsd_checker (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     i_in_ready,
    input logic                     i_in_operation,
    input logic                     i_out_valid,
    input logic                     i_out_ready,
    input logic [hbsd_pkg::SYM_W-1:0] i_out_symbol,
    input logic                     i_out_error
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_symbol) && $stable(i_out_error))
        else $error("result payload changed while stalled");

    // Overflow results carry no symbol, matches always carry one
    a_err_sym: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_error |-> i_out_symbol == '0)
        else $error("overflow result with a symbol");

    a_match_sym: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_error |-> i_out_symbol != '0)
        else $error("match result without a symbol");

    // A decode occupies the chain, so no transfer follows it directly
    a_dec_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_operation == hbsd_pkg::OP_DECODE |=> !i_in_ready)
        else $error("input ready right after a decode");

endmodule

bind huffman_bit_serial_decoder_unit hbsd_checker u_hbsd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_operation (i_in.operation),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_symbol   (o_out.symbol_out),
    .i_out_error    (o_out.overflow_error)
);

// ===== test/testbench.sv =====
// Self-checking testbench of the bit-serial Huffman decoder: table loads, code bits, results.
`timescale 1ns / 100ps

module testbench;

    localparam int TBL_DEPTH    = 256;
    localparam int MAX_LEN      = 16;
    localparam int ITEM_TARGET  = 750;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int STALL_CYCLES = 4000;

    // One input transfer and one result transfer
    typedef struct packed {
        logic                        op;
        logic [hbsd_pkg::IDX_W-1:0]  idx;
        logic [hbsd_pkg::CODE_W-1:0] code;
        logic [hbsd_pkg::LEN_W-1:0]  len;
        logic [hbsd_pkg::SYM_W-1:0]  sym;
        logic                        cbit;
    } t_hbsd_item;

    typedef struct packed {
        logic [hbsd_pkg::SYM_W-1:0] sym;
        logic                       ovf;
    } t_hbsd_result;

    logic i_clk;
    logic i_rst_n;

    hbsd_in_if  in_if ();
    hbsd_out_if out_if ();

    huffman_bit_serial_decoder_unit #(
        .TABLE_DEPTH  (TBL_DEPTH),
        .MAX_CODE_LEN (MAX_LEN)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Decoder shadow: slot table and pending code
    logic [hbsd_pkg::CODE_W-1:0] tbl_code [TBL_DEPTH];
    logic [hbsd_pkg::LEN_W-1:0]  tbl_len  [TBL_DEPTH];
    logic [hbsd_pkg::SYM_W-1:0]  tbl_sym  [TBL_DEPTH];
    logic [MAX_LEN-1:0] acc_code;
    int                 acc_len;

    // Table as the stimulus generator intends it
    logic [hbsd_pkg::CODE_W-1:0] gen_code [TBL_DEPTH];
    int                gen_len  [TBL_DEPTH];
    int                gen_sym  [TBL_DEPTH];
    int                live_q [$];

    t_hbsd_item   item_q [$];
    t_hbsd_result symbol_q [$];
    t_hbsd_item   nxt;

    int   total_items;
    int   accepted_cnt;
    int   errors;
    int   cycle_cnt;
    int   send_gap;
    int   rx_hold;
    int   stall_left;
    bit   stall_done;
    logic in_fire;
    logic calm;

    // Periodic stretches with no idling on either side
    assign calm = (cycle_cnt % 3000) < 400;

    always #2 i_clk = ~i_clk;

    function automatic logic [31:0] len_mask(input int n);
        if (n >= 32)
            return 32'hFFFF_FFFF;
        return (32'd1 << n) - 32'd1;
    endfunction

    function automatic int pick_gap(input int longest);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(30, longest);
    endfunction

    function automatic bit gen_live(input int s);
        return gen_len[s] != 0 && gen_len[s] <= MAX_LEN && gen_sym[s] != 0;
    endfunction

    // A new code must be no prefix of a live code, and no live code a prefix of it
    function automatic bit fits_code_space(input logic [hbsd_pkg::CODE_W-1:0] code,
                                           input int len);
        int m;
        for (int s = 0; s < TBL_DEPTH; s++) begin
            if (gen_live(s)) begin
                m = (len < gen_len[s]) ? len : gen_len[s];
                if (((32'(code) >> (len - m)) & len_mask(m)) ==
                    ((32'(gen_code[s]) >> (gen_len[s] - m)) & len_mask(m)))
                    return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    task automatic collect_live();
        live_q.delete();
        for (int s = 0; s < TBL_DEPTH; s++)
            if (gen_live(s))
                live_q = {live_q, s};
    endtask

    task automatic queue_load(input int slot, input logic [hbsd_pkg::CODE_W-1:0] code,
                              input int len, input int sym);
        t_hbsd_item it;
        it.op   = hbsd_pkg::OP_LOAD;
        it.idx  = hbsd_pkg::IDX_W'(slot);
        it.code = code;
        it.len  = hbsd_pkg::LEN_W'(len);
        it.sym  = hbsd_pkg::SYM_W'(sym);
        it.cbit = 1'($urandom);
        item_q = {item_q, it};
        gen_code[slot] = code;
        gen_len[slot]  = len;
        gen_sym[slot]  = sym;
    endtask

    task automatic queue_bit(input logic b);
        t_hbsd_item it;
        it.op   = hbsd_pkg::OP_DECODE;
        it.idx  = hbsd_pkg::IDX_W'($urandom);
        it.code = hbsd_pkg::CODE_W'($urandom);
        it.len  = hbsd_pkg::LEN_W'($urandom);
        it.sym  = hbsd_pkg::SYM_W'($urandom);
        it.cbit = b;
        item_q = {item_q, it};
    endtask

    // Leading nbits of a slot's code, first bit first
    task automatic queue_word(input int slot, input int nbits);
        for (int k = gen_len[slot] - 1; k >= gen_len[slot] - nbits; k--)
            queue_bit(gen_code[slot][k]);
    endtask

    // Slot that decodes nothing: no length, no symbol, or too long
    task automatic queue_dead_entry(input int slot);
        case ($urandom_range(0, 2))
            0:       queue_load(slot, hbsd_pkg::CODE_W'($urandom), 0, $urandom_range(0, 255));
            1:       queue_load(slot, hbsd_pkg::CODE_W'($urandom), $urandom_range(1, 16), 0);
            default: queue_load(slot, hbsd_pkg::CODE_W'($urandom), $urandom_range(17, 31),
                                $urandom_range(0, 255));
        endcase
    endtask

    task automatic flag_mismatch(input string msg);
        $display("ERROR at cycle %0d: %s", cycle_cnt, msg);
        errors++;
    endtask

    // Expected result of one accepted transfer, if any
    task automatic decode_predict(input t_hbsd_item it);
        t_hbsd_result res;
        bit           hit;
        int           el;
        if (it.op == hbsd_pkg::OP_LOAD) begin
            if (int'(it.idx) < TBL_DEPTH) begin
                tbl_code[it.idx] = it.code;
                tbl_len[it.idx]  = it.len;
                tbl_sym[it.idx]  = it.sym;
            end
        end else begin
            acc_code = {acc_code[MAX_LEN-2:0], it.cbit};
            acc_len++;
            hit = 1'b0;
            // lowest matching slot wins
            for (int i = 0; i < TBL_DEPTH; i++) begin
                el = int'(tbl_len[i]);
                if (!hit && el != 0 && tbl_sym[i] != 0 && el == acc_len &&
                    (32'(tbl_code[i]) & len_mask(el)) == 32'(acc_code)) begin
                    hit     = 1'b1;
                    res.sym = tbl_sym[i];
                    res.ovf = 1'b0;
                end
            end
            if (!hit && acc_len >= MAX_LEN) begin
                hit     = 1'b1;
                res.sym = '0;
                res.ovf = 1'b1;
            end
            if (hit) begin
                symbol_q = {symbol_q, res};
                acc_code = '0;
                acc_len  = 0;
            end
        end
    endtask

    // Sample both channels at the rising edge
    always @(posedge i_clk) begin
        t_hbsd_result want;
        t_hbsd_item   got;
        cycle_cnt <= cycle_cnt + 1;
        in_fire   <= i_rst_n && in_if.valid && in_if.ready;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (symbol_q.size() == 0) begin
                flag_mismatch($sformatf("unexpected result sym=%h ovf=%b",
                                        out_if.symbol_out, out_if.overflow_error));
            end else begin
                want = symbol_q[0];
                symbol_q.delete(0);
                if (out_if.symbol_out !== want.sym)
                    flag_mismatch($sformatf("symbol_out %h, expected %h",
                                            out_if.symbol_out, want.sym));
                if (out_if.overflow_error !== want.ovf)
                    flag_mismatch($sformatf("overflow_error %b, expected %b",
                                            out_if.overflow_error, want.ovf));
            end
        end
        if (i_rst_n && in_if.valid && in_if.ready) begin
            got.op   = in_if.operation;
            got.idx  = in_if.entry_index;
            got.code = in_if.entry_code;
            got.len  = in_if.entry_length;
            got.sym  = in_if.entry_symbol;
            got.cbit = in_if.code_bit;
            decode_predict(got);
            accepted_cnt++;
        end
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Input driver: next transfer once the current one is taken, with random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!(in_if.valid && !in_fire)) begin
            if (send_gap > 0) begin
                in_if.valid <= 1'b0;
                send_gap    <= send_gap - 1;
            end else if (item_q.size() != 0) begin
                nxt                = item_q[0];
                item_q.delete(0);
                in_if.operation    <= nxt.op;
                in_if.entry_index  <= nxt.idx;
                in_if.entry_code   <= nxt.code;
                in_if.entry_length <= nxt.len;
                in_if.entry_symbol <= nxt.sym;
                in_if.code_bit     <= nxt.cbit;
                in_if.valid        <= 1'b1;
                send_gap           <= pick_gap(300);
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // One long receiver hold-off so the block backs up into its input
    always @(negedge i_clk) begin
        if (!stall_done && accepted_cnt >= 250) begin
            stall_left <= STALL_CYCLES;
            stall_done <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end
    end

    // Result receiver ready with random stalls
    always @(negedge i_clk) begin
        if (!i_rst_n || stall_left > 0) begin
            out_if.ready <= 1'b0;
        end else if (rx_hold > 0) begin
            out_if.ready <= 1'b0;
            rx_hold      <= rx_hold - 1;
        end else begin
            out_if.ready <= 1'b1;
            rx_hold      <= pick_gap(60);
        end
    end

    initial begin
        int               phase_end;
        int               n;
        int               len;
        int               slot;
        int               tries;
        int               j;
        int               r;
        bit               placed;
        logic [hbsd_pkg::CODE_W-1:0] code;

        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        in_if.valid        = 1'b0;
        in_if.operation    = hbsd_pkg::OP_LOAD;
        in_if.entry_index  = '0;
        in_if.entry_code   = '0;
        in_if.entry_length = '0;
        in_if.entry_symbol = '0;
        in_if.code_bit     = 1'b0;
        out_if.ready       = 1'b0;
        in_fire            = 1'b0;
        cycle_cnt          = 0;
        accepted_cnt       = 0;
        errors             = 0;
        send_gap           = 0;
        rx_hold            = 0;
        stall_left         = 0;
        stall_done         = 1'b0;
        acc_code           = '0;
        acc_len            = 0;
        for (int s = 0; s < TBL_DEPTH; s++) begin
            tbl_code[s] = '0;
            tbl_len[s]  = '0;
            tbl_sym[s]  = '0;
            gen_code[s] = '0;
            gen_len[s]  = 0;
            gen_sym[s]  = 0;
        end

        // Directed: duplicate code (lower slot wins), junk above the length,
        // unused slots, over-long entry, longest code, overflow
        queue_load(3,   16'h0000, 1,  8'h5A);
        queue_load(5,   16'hFFFE, 1,  8'h41);
        queue_load(0,   16'hAAAA, 2,  8'h80);
        queue_load(1,   16'hFFFF, 31, 8'h01);
        queue_load(2,   16'h0006, 3,  8'h00);
        queue_load(4,   16'h0007, 0,  8'h33);
        queue_load(255, 16'hFFFE, 16, 8'hFF);
        queue_bit(1'b0);
        queue_bit(1'b1);
        queue_bit(1'b0);
        // "110" hits the symbol-less slot, then 13 more ones reach 16 bits with no match
        queue_bit(1'b1);
        queue_bit(1'b1);
        queue_bit(1'b0);
        repeat (13) queue_bit(1'b1);

        // Random phases: fresh prefix-free table, then mostly whole code words
        while (item_q.size() < ITEM_TARGET) begin
            collect_live();
            foreach (live_q[q])
                queue_dead_entry(live_q[q]);
            if ($urandom_range(0, 1))
                queue_load(255, hbsd_pkg::CODE_W'($urandom), MAX_LEN,
                           $urandom_range(1, 255));
            n = $urandom_range(4, 16);
            for (int e = 0; e < n; e++) begin
                tries  = 0;
                placed = 1'b0;
                while (tries < 30 && !placed) begin
                    len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 16)
                                                       : $urandom_range(1, 10);
                    code = hbsd_pkg::CODE_W'($urandom);
                    slot = $urandom_range(0, TBL_DEPTH - 1);
                    if (!gen_live(slot) && fits_code_space(code, len)) begin
                        queue_load(slot, code, len, $urandom_range(1, 255));
                        placed = 1'b1;
                    end
                    tries++;
                end
            end
            // same code in two slots
            collect_live();
            if ($urandom_range(0, 2) == 0 && live_q.size() != 0) begin
                j = live_q[$urandom_range(0, live_q.size() - 1)];
                do slot = $urandom_range(0, TBL_DEPTH - 1); while (gen_live(slot));
                code = hbsd_pkg::CODE_W'(($urandom & ~len_mask(gen_len[j])) |
                                         (32'(gen_code[j]) & len_mask(gen_len[j])));
                queue_load(slot, code, gen_len[j], $urandom_range(1, 255));
            end

            phase_end = item_q.size() + $urandom_range(60, 140);
            while (item_q.size() < phase_end && item_q.size() < ITEM_TARGET) begin
                collect_live();
                r = $urandom_range(0, 99);
                if (live_q.size() != 0)
                    j = live_q[$urandom_range(0, live_q.size() - 1)];
                if (r < 80 && live_q.size() != 0) begin
                    queue_word(j, gen_len[j]);
                end else if (r < 88 && live_q.size() != 0 && gen_len[j] > 1) begin
                    queue_word(j, $urandom_range(1, gen_len[j] - 1));
                end else if (r < 95) begin
                    repeat ($urandom_range(1, 4)) queue_bit(1'($urandom));
                end else begin
                    do slot = $urandom_range(0, TBL_DEPTH - 1); while (gen_live(slot));
                    queue_dead_entry(slot);
                end
            end
        end
        total_items = item_q.size();

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: every transfer taken, every result seen, then a settling wait
        wait (accepted_cnt == total_items);
        wait (symbol_q.size() == 0);
        repeat (2 * (TBL_DEPTH + 1) + 20) @(posedge i_clk);

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
